// ----- design/owm_pkg.sv -----
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, codes, reset values and the CRC-8 step for the one-wire master.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

    // Command codes carried on the request side.
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_RESET = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_RESET_LOW_TIME    = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT     = 3'd1;
    localparam logic [2:0] REG_PRESENCE_TAIL     = 3'd2;
    localparam logic [2:0] REG_SLOT_TIME         = 3'd3;
    localparam logic [2:0] REG_READ_SAMPLE_DELAY = 3'd4;
    localparam logic [2:0] REG_RECOVERY_TIME     = 3'd5;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    // Register values after reset.
    localparam logic [9:0] RESET_LOW_TIME_RST    = 10'd480;
    localparam logic [7:0] PRESENCE_WAIT_RST     = 8'd60;
    localparam logic [9:0] PRESENCE_TAIL_RST     = 10'd420;
    localparam logic [7:0] SLOT_TIME_RST         = 8'd60;
    localparam logic [7:0] READ_SAMPLE_DELAY_RST = 8'd5;
    localparam logic [7:0] RECOVERY_TIME_RST     = 8'd1;

    // Reflected Dallas polynomial.
    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] presence_wait;
        logic [9:0] presence_tail;
        logic [7:0] slot_time;
        logic [7:0] read_sample_delay;
        logic [7:0] recovery_time;
    } cfg_t;

    // One result as it leaves the engine.
    typedef struct packed {
        logic       rejected;
        logic [7:0] crc_value;
        logic [7:0] read_data;
        logic       presence;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } res_t;

    // Durations of zero count as one.
    function automatic logic [9:0] at_least_one10(input logic [9:0] v);
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

    function automatic logic [7:0] at_least_one8(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    // Folds one byte into the running CRC, LSB first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] b;
        logic       mix;
        crc = crc_in;
        b   = data;
        for (int i = 0; i < 8; i++)
        begin
            mix = crc[0] ^ b[0];
            crc = crc >> 1;
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ----- design/owm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// owm_cfg_regs
// Timing registers of the one-wire master, written through a plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_cfg_regs
    import owm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    assign cfg = cfg_reg;

    // Register file; writes beyond the last index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time    <= RESET_LOW_TIME_RST;
            cfg_reg.presence_wait     <= PRESENCE_WAIT_RST;
            cfg_reg.presence_tail     <= PRESENCE_TAIL_RST;
            cfg_reg.slot_time         <= SLOT_TIME_RST;
            cfg_reg.read_sample_delay <= READ_SAMPLE_DELAY_RST;
            cfg_reg.recovery_time     <= RECOVERY_TIME_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_RESET_LOW_TIME:    cfg_reg.reset_low_time    <= cfg_wdata;
                REG_PRESENCE_WAIT:     cfg_reg.presence_wait     <= cfg_wdata[7:0];
                REG_PRESENCE_TAIL:     cfg_reg.presence_tail     <= cfg_wdata;
                REG_SLOT_TIME:         cfg_reg.slot_time         <= cfg_wdata[7:0];
                REG_READ_SAMPLE_DELAY: cfg_reg.read_sample_delay <= cfg_wdata[7:0];
                REG_RECOVERY_TIME:     cfg_reg.recovery_time     <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/owm_engine.sv -----
// ----------------------------------------------------------------------------
// owm_engine
// Bus sequencer: advances reset, write and read slots by one tick per tick request.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_engine
    import owm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [1:0] func,
    input  wire logic [7:0] data_byte,
    input  wire logic       line_level,
    input  wire cfg_t       cfg,
    output res_t            res
);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_TAIL = 3'd3,
        PH_WR_LOW   = 3'd4,
        PH_WR_REL   = 3'd5,
        PH_RD_LOW   = 3'd6,
        PH_RD_REL   = 3'd7
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [9:0] tick_count_reg, tick_count_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] read_byte_reg, read_byte_next;
    logic [7:0] crc_reg, crc_next;
    logic       presence_reg, presence_next;
    logic       done;
    logic       rejected;

    logic [9:0] tc_inc;
    logic [7:0] slot1;
    logic [7:0] rsd1;
    logic [7:0] smp;
    logic [7:0] low_len;
    logic [8:0] rel_len;
    logic       last_bit;
    logic [7:0] rd_shift;

    // Slot timing derived from the current bit and the registers.
    always_comb
    begin
        tc_inc   = tick_count_reg + 10'd1;
        slot1    = at_least_one8(cfg.slot_time);
        rsd1     = at_least_one8(cfg.read_sample_delay);
        smp      = (rsd1 > slot1) ? slot1 : rsd1;
        low_len  = shift_byte_reg[0] ? 8'd1 : slot1;
        rel_len  = (shift_byte_reg[0] ? {1'b0, slot1} : 9'd0) + {1'b0, cfg.recovery_time};
        last_bit = (bit_index_reg == 3'd7);
        rd_shift = shift_byte_reg;
        if (line_level && (tc_inc == {2'b00, smp}))
        begin
            rd_shift = shift_byte_reg | (8'd1 << bit_index_reg);
        end
    end

    // Next state for one request.
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        read_byte_next  = read_byte_reg;
        crc_next        = crc_reg;
        presence_next   = presence_reg;
        done            = 1'b0;
        rejected        = 1'b0;

        if (func == FUNC_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                tick_count_next = tc_inc;
                case (phase_reg)
                    PH_RST_LOW:
                    begin
                        if (tc_inc >= at_least_one10(cfg.reset_low_time))
                        begin
                            phase_next      = PH_RST_WAIT;
                            tick_count_next = 10'd0;
                        end
                    end
                    PH_RST_WAIT:
                    begin
                        if (tc_inc >= {2'b00, at_least_one8(cfg.presence_wait)})
                        begin
                            presence_next   = ~line_level;
                            phase_next      = PH_RST_TAIL;
                            tick_count_next = 10'd0;
                        end
                    end
                    PH_RST_TAIL:
                    begin
                        if (tc_inc >= at_least_one10(cfg.presence_tail))
                        begin
                            phase_next      = PH_IDLE;
                            tick_count_next = 10'd0;
                            done            = 1'b1;
                        end
                    end
                    PH_WR_LOW, PH_WR_REL:
                    begin
                        // The low part ends first; a zero-length released part is skipped.
                        if ((phase_reg == PH_WR_LOW) && (tc_inc >= {2'b00, low_len}) &&
                            (rel_len != 9'd0))
                        begin
                            phase_next      = PH_WR_REL;
                            tick_count_next = 10'd0;
                        end
                        else if (((phase_reg == PH_WR_LOW) && (tc_inc >= {2'b00, low_len})) ||
                                 ((phase_reg == PH_WR_REL) && (tc_inc >= {1'b0, rel_len})))
                        begin
                            tick_count_next = 10'd0;
                            if (last_bit)
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                bit_index_next  = bit_index_reg + 3'd1;
                                shift_byte_next = shift_byte_reg >> 1;
                                phase_next      = PH_WR_LOW;
                            end
                        end
                    end
                    PH_RD_LOW:
                    begin
                        phase_next      = PH_RD_REL;
                        tick_count_next = 10'd0;
                    end
                    default:
                    begin
                        // Released part of a read slot.
                        shift_byte_next = rd_shift;
                        if (tc_inc >= {2'b00, slot1})
                        begin
                            tick_count_next = 10'd0;
                            if (last_bit)
                            begin
                                read_byte_next = rd_shift;
                                crc_next       = crc8_update(crc_reg, rd_shift);
                                phase_next     = PH_IDLE;
                                done           = 1'b1;
                            end
                            else
                            begin
                                bit_index_next = bit_index_reg + 3'd1;
                                phase_next     = PH_RD_LOW;
                            end
                        end
                    end
                endcase
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            rejected = 1'b1;
        end
        else
        begin
            tick_count_next = 10'd0;
            bit_index_next  = 3'd0;
            case (func)
                FUNC_RESET:
                begin
                    presence_next = 1'b0;
                    crc_next      = 8'd0;
                    phase_next    = PH_RST_LOW;
                end
                FUNC_WRITE:
                begin
                    shift_byte_next = data_byte;
                    phase_next      = PH_WR_LOW;
                end
                default:
                begin
                    shift_byte_next = 8'd0;
                    phase_next      = PH_RD_LOW;
                end
            endcase
        end
    end

    // Result fields as seen after this request's update.
    always_comb
    begin
        res.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
                        (phase_next == PH_RD_LOW);
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = done;
        res.presence  = presence_next;
        res.read_data = read_byte_next;
        res.crc_value = crc_next;
        res.rejected  = rejected;
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= 10'd0;
            bit_index_reg  <= 3'd0;
            shift_byte_reg <= 8'd0;
            read_byte_reg  <= 8'd0;
            crc_reg        <= 8'd0;
            presence_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            read_byte_reg  <= read_byte_next;
            crc_reg        <= crc_next;
            presence_reg   <= presence_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/one_wire_master_crc8_core.sv -----
// ----------------------------------------------------------------------------
// one_wire_master_crc8_core
// One-wire bus master with Dallas CRC-8 over bytes read, paced by tick requests.
// ----------------------------------------------------------------------------
// Usage. Each request on the s_axis side is either a one-microsecond tick
// carrying the sampled bus level, or a command (bus reset, write byte, read
// byte) selected by s_axis_tuser. Every request yields exactly one result on
// the m_axis side: the drive level for the next tick, busy, done, presence,
// the last byte read, the running CRC and a rejected flag for a command that
// arrived while an operation was running.
// Path: a request is held in the input register; once the output register can
// take its result, the result is loaded there and stays valid until taken.
// Throughput: one request per clock cycle while no result is stalled.
// Stalls: while a result waits for m_axis_tready, the input register still
// takes one more request; further requests wait on s_axis_tready.
// Reset: rst_n clears the valid flags of both registers, the sequencer (idle,
// CRC zero, no presence) and restores the default timing registers. Timing
// registers are written through cfg_we/cfg_addr/cfg_wdata; the user must write
// them only while the block is idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_master_crc8_core
    import owm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Request side.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,  // data_byte[7:0], line_level[8], zero
    input  wire logic [1:0]            s_axis_tuser,  // func[1:0]
    // Result side.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [23:0]                m_axis_tdata   // drive_low[0], busy_res[1],
                                                      // done_res[2], presence[3],
                                                      // read_data[11:4], crc_value[19:12],
                                                      // rejected[20], zero
);

    cfg_t       cfg;
    res_t       res;
    logic       in_valid_reg;
    logic [1:0] in_func_reg;
    logic [7:0] in_data_reg;
    logic       in_line_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;
    logic       step;

    owm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // A held request is processed when the output register can take its result.
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    owm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .func       (in_func_reg),
        .data_byte  (in_data_reg),
        .line_level (in_line_reg),
        .cfg        (cfg),
        .res        (res)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_func_reg <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[7:0];
            in_line_reg <= s_axis_tdata[8];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_res_reg};

endmodule

`default_nettype wire

// ----- design/owm_checker.sv -----
// ----------------------------------------------------------------------------
// owm_checker
// Port-level checks on the one-wire master's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A rejected command never finishes an operation.
    a_done_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[20]))
        else $error("done and rejected in one result");

    // The bus is only pulled low while an operation runs.
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("drive low while not busy");

    // A finished operation leaves the master idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1])
        else $error("done while still busy");

endmodule

bind one_wire_master_crc8_core owm_checker u_owm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- bench/tb_one_wire_master_crc8_core.sv -----
// ----------------------------------------------------------------------------
// tb_one_wire_master_crc8_core
// Self-checking bench for the one-wire master with its running CRC-8.
// ----------------------------------------------------------------------------
// Every request is mirrored into a cycle-free model of the bus sequencer. The
// model queues the one result that each request must produce, and every result
// taken from the block is compared field by field with the oldest queued one.
// Timing registers change only between phases, with the block drained. The run
// covers all-zero timing and small random timings, where a sample point past
// the end of the slot and a zero recovery gap both occur, under three patterns
// of request gaps and result stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_one_wire_master_crc8_core;
    import owm_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // Sequencer phases of the bus model.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_WAIT,
        SEQ_RST_TAIL,
        SEQ_WR_LOW,
        SEQ_WR_REL,
        SEQ_RD_LOW,
        SEQ_RD_REL
    } seq_phase_t;

    // Bus sequencer model plus the queue of results it still owes.
    class owm_scoreboard;
        logic [9:0] rst_low_t;
        logic [7:0] pres_wait_t;
        logic [9:0] pres_tail_t;
        logic [7:0] slot_t;
        logic [7:0] sample_t;
        logic [7:0] recov_t;

        seq_phase_t phase;
        logic [9:0] ticks;
        logic [2:0] bit_no;
        logic [7:0] shreg;
        logic [7:0] rx_byte;
        logic [7:0] crc;
        logic       pres;
        logic [1:0] op;

        res_t results_due[$];
        int   errors;

        function new();
            rst_low_t   = RESET_LOW_TIME_RST;
            pres_wait_t = PRESENCE_WAIT_RST;
            pres_tail_t = PRESENCE_TAIL_RST;
            slot_t      = SLOT_TIME_RST;
            sample_t    = READ_SAMPLE_DELAY_RST;
            recov_t     = RECOVERY_TIME_RST;
            phase       = SEQ_IDLE;
            ticks       = '0;
            bit_no      = '0;
            shreg       = '0;
            rx_byte     = '0;
            crc         = '0;
            pres        = 1'b0;
            op          = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_RESET_LOW_TIME:    rst_low_t   = val[9:0];
                REG_PRESENCE_WAIT:     pres_wait_t = val[7:0];
                REG_PRESENCE_TAIL:     pres_tail_t = val[9:0];
                REG_SLOT_TIME:         slot_t      = val[7:0];
                REG_READ_SAMPLE_DELAY: sample_t    = val[7:0];
                REG_RECOVERY_TIME:     recov_t     = val[7:0];
                default: ;
            endcase
        endfunction

        function bit is_idle();
            return phase == SEQ_IDLE;
        endfunction

        function int unsigned at_least1(int unsigned v);
            return (v == 0) ? 1 : v;
        endfunction

        // Reflected Dallas CRC, one data bit per step, LSB first.
        function logic [7:0] crc_fold(logic [7:0] c, logic [7:0] b);
            for (int i = 0; i < 8; i++)
            begin
                c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function int unsigned write_low_len();
            return shreg[0] ? 1 : at_least1(slot_t);
        endfunction

        function int unsigned write_rel_len();
            return (shreg[0] ? at_least1(slot_t) : 0) + recov_t;
        endfunction

        // Steps to the next written bit; true once the last bit is out.
        function bit next_write_bit();
            ticks = '0;
            if (bit_no == 3'd7)
            begin
                phase = SEQ_IDLE;
                return 1'b1;
            end
            bit_no = bit_no + 3'd1;
            shreg  = shreg >> 1;
            phase  = SEQ_WR_LOW;
            return 1'b0;
        endfunction

        // One microsecond of bus time; returns true when an operation ends.
        function bit advance_tick(logic ln);
            int unsigned len;
            int unsigned smp;
            bit          fin;
            fin = 1'b0;
            if (phase == SEQ_IDLE)
            begin
                return 1'b0;
            end
            ticks = ticks + 10'd1;
            case (phase)
                SEQ_RST_LOW:
                begin
                    if (ticks >= at_least1(rst_low_t))
                    begin
                        phase = SEQ_RST_WAIT;
                        ticks = '0;
                    end
                end
                SEQ_RST_WAIT:
                begin
                    if (ticks >= at_least1(pres_wait_t))
                    begin
                        pres  = ~ln;
                        phase = SEQ_RST_TAIL;
                        ticks = '0;
                    end
                end
                SEQ_RST_TAIL:
                begin
                    if (ticks >= at_least1(pres_tail_t))
                    begin
                        phase = SEQ_IDLE;
                        ticks = '0;
                        fin   = 1'b1;
                    end
                end
                SEQ_WR_LOW:
                begin
                    if (ticks >= write_low_len())
                    begin
                        if (write_rel_len() == 0)
                        begin
                            fin = next_write_bit();
                        end
                        else
                        begin
                            phase = SEQ_WR_REL;
                            ticks = '0;
                        end
                    end
                end
                SEQ_WR_REL:
                begin
                    if (ticks >= write_rel_len())
                    begin
                        fin = next_write_bit();
                    end
                end
                SEQ_RD_LOW:
                begin
                    phase = SEQ_RD_REL;
                    ticks = '0;
                end
                default:
                begin
                    // Sample point is clamped into the released part of the slot.
                    len = at_least1(slot_t);
                    smp = at_least1(sample_t);
                    if (smp > len)
                    begin
                        smp = len;
                    end
                    if (ticks == smp && ln)
                    begin
                        shreg[bit_no] = 1'b1;
                    end
                    if (ticks >= len)
                    begin
                        if (bit_no == 3'd7)
                        begin
                            rx_byte = shreg;
                            crc     = crc_fold(crc, shreg);
                            phase   = SEQ_IDLE;
                            fin     = 1'b1;
                        end
                        else
                        begin
                            bit_no = bit_no + 3'd1;
                            phase  = SEQ_RD_LOW;
                        end
                        ticks = '0;
                    end
                end
            endcase
            return fin;
        endfunction

        // Applies one accepted request and queues the result it must produce.
        function void note_request(func_t f, logic [7:0] d, logic ln);
            res_t r;
            logic fin;
            logic rej;
            fin = 1'b0;
            rej = 1'b0;
            if (f == FUNC_TICK)
            begin
                fin = advance_tick(ln);
            end
            else if (phase != SEQ_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                op     = f;
                ticks  = '0;
                bit_no = '0;
                case (f)
                    FUNC_RESET:
                    begin
                        pres  = 1'b0;
                        crc   = '0;
                        phase = SEQ_RST_LOW;
                    end
                    FUNC_WRITE:
                    begin
                        shreg = d;
                        phase = SEQ_WR_LOW;
                    end
                    default:
                    begin
                        shreg = '0;
                        phase = SEQ_RD_LOW;
                    end
                endcase
            end
            r.drive_low = (phase == SEQ_RST_LOW) || (phase == SEQ_WR_LOW) ||
                          (phase == SEQ_RD_LOW);
            r.busy_res  = (phase != SEQ_IDLE);
            r.done_res  = fin;
            r.presence  = pres;
            r.read_data = rx_byte;
            r.crc_value = crc;
            r.rejected  = rej;
            results_due.push_back(r);
        endfunction

        // Compares one result word with the oldest queued result.
        function void check_result(logic [23:0] word);
            res_t exp_r;
            res_t act_r;
            bit   bad;
            act_r = res_t'(word[20:0]);
            if (results_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: result %06h arrived with none outstanding", word);
                end
                return;
            end
            exp_r = results_due.pop_front();
            bad = (act_r.drive_low !== exp_r.drive_low) ||
                  (act_r.busy_res  !== exp_r.busy_res)  ||
                  (act_r.done_res  !== exp_r.done_res)  ||
                  (act_r.presence  !== exp_r.presence)  ||
                  (act_r.read_data !== exp_r.read_data) ||
                  (act_r.crc_value !== exp_r.crc_value) ||
                  (act_r.rejected  !== exp_r.rejected)  ||
                  (word[23:21] !== 3'b000);
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR @%0t: drv/busy/done/pres/rd/crc/rej", $realtime);
                    $display("       exp %0d %0d %0d %0d %02h %02h %0d",
                             exp_r.drive_low, exp_r.busy_res, exp_r.done_res,
                             exp_r.presence, exp_r.read_data, exp_r.crc_value, exp_r.rejected);
                    $display("       got %0d %0d %0d %0d %02h %02h %0d (pad %0d)",
                             act_r.drive_low, act_r.busy_res, act_r.done_res, act_r.presence,
                             act_r.read_data, act_r.crc_value, act_r.rejected, word[23:21]);
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;   // data_byte[7:0], line_level[8], zero
    logic [1:0]            s_axis_tuser;   // func[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;   // drive_low[0], busy_res[1], done_res[2],
                                           // presence[3], read_data[11:4],
                                           // crc_value[19:12], rejected[20], zero

    owm_scoreboard sb = new();
    int            send_idle;
    int            recv_idle;
    int            items_sent;

    one_wire_master_crc8_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side back-pressure.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Every result taken from the block is checked here.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata);
        end
    end

    // Ends the run when no request and no result moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("tb_one_wire_master_crc8_core: done, errors");
        $finish;
    end

    // Presents one request, waits for it to be taken, then updates the model.
    task automatic send_item(input func_t f, input logic [7:0] d, input logic ln);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {7'd0, ln, d};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        sb.note_request(f, d, ln);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(REG_RESET_LOW_TIME, c.reset_low_time);
        write_reg(REG_PRESENCE_WAIT, 10'(c.presence_wait));
        write_reg(REG_PRESENCE_TAIL, c.presence_tail);
        write_reg(REG_SLOT_TIME, 10'(c.slot_time));
        write_reg(REG_READ_SAMPLE_DELAY, 10'(c.read_sample_delay));
        write_reg(REG_RECOVERY_TIME, 10'(c.recovery_time));
        cfg_we <= 1'b0;
    endtask

    // Short timings keep operations to a few dozen ticks.
    function automatic cfg_t small_timing();
        cfg_t c;
        c.reset_low_time    = 10'($urandom_range(12));
        c.presence_wait     = 8'($urandom_range(8));
        c.presence_tail     = 10'($urandom_range(12));
        c.slot_time         = 8'($urandom_range(8));
        c.read_sample_delay = 8'($urandom_range(10));
        c.recovery_time     = 8'($urandom_range(4));
        return c;
    endfunction

    // Finishes the bus operation, then waits until every result is back.
    task automatic quiesce();
        while (!sb.is_idle())
        begin
            send_item(FUNC_TICK, 8'($urandom), 1'($urandom));
        end
        s_axis_tvalid <= 1'b0;
        while (sb.results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // A command followed by ticks until it completes, with stray commands mixed in.
    task automatic run_one_op(input func_t f, input logic [7:0] d);
        send_item(f, d, 1'($urandom));
        while (!sb.is_idle())
        begin
            if ($urandom_range(99) < 5)
            begin
                send_item(func_t'(2'($urandom_range(3, 1))), 8'($urandom), 1'($urandom));
            end
            else
            begin
                send_item(FUNC_TICK, 8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic run_ops(input int count);
        int         target;
        logic [7:0] d;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_item(FUNC_TICK, 8'($urandom), 1'($urandom));
            end
            else
            begin
                case ($urandom_range(9))
                    0:       d = 8'h00;
                    1:       d = 8'hFF;
                    default: d = 8'($urandom);
                endcase
                run_one_op(func_t'(2'($urandom_range(3, 1))), d);
            end
        end
    endtask

    initial
    begin : stimulus
        items_sent    = 0;
        send_idle     = 35;
        recv_idle     = 67;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= '0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_TICK;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All-zero timing: every duration but recovery acts as one.
        apply_config('0);
        send_item(FUNC_TICK, 8'hFF, 1'b1);
        send_item(FUNC_RESET, 8'h00, 1'b0);
        send_item(FUNC_WRITE, 8'hA5, 1'b0);
        repeat (3) send_item(FUNC_TICK, 8'h00, 1'b0);
        send_item(FUNC_READ, 8'h00, 1'b1);
        send_item(FUNC_RESET, 8'hFF, 1'b1);
        repeat (16) send_item(FUNC_TICK, 8'h5A, 1'b1);
        run_ops(120);
        quiesce();

        apply_config(small_timing());
        run_ops(160);
        quiesce();

        // Sender slow, receiver mostly ready.
        send_idle = 67;
        recv_idle = 35;
        apply_config(small_timing());
        run_ops(160);
        quiesce();
        apply_config(small_timing());
        run_ops(160);
        quiesce();

        // Full speed on both sides.
        send_idle = 0;
        recv_idle = 0;
        apply_config(small_timing());
        run_ops(160);
        quiesce();
        repeat (10) @(posedge clk);

        if (sb.errors == 0 && sb.results_due.size() == 0)
        begin
            $display("tb_one_wire_master_crc8_core: done, clean");
        end
        else
        begin
            $display("tb_one_wire_master_crc8_core: done, errors");
        end
        $finish;
    end

endmodule

// ----- one_wire_master_crc8_core.f -----
design/owm_pkg.sv
design/owm_cfg_regs.sv
design/owm_engine.sv
design/one_wire_master_crc8_core.sv
design/owm_checker.sv
bench/tb_one_wire_master_crc8_core.sv
